@@ src/lss_pkg.sv @@
`default_nettype none
package lss_pkg;

  localparam int MaxSize = 8;
  localparam int NumCol  = MaxSize + 1;
  localparam int Depth   = MaxSize * NumCol;

  localparam logic [3:0] BCol = 4'(MaxSize);

  typedef enum logic [0:0] {
    REG_SIZE = 1'b0,
    REG_THR  = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_COPY,
    S_PIV_RD,
    S_PIV_CHK,
    S_PIV_DEC,
    S_F_RD,
    S_F_DIV,
    S_F_WAIT,
    S_U_RDA,
    S_U_RDB,
    S_U_MUL,
    S_U_WR,
    S_NEXT_I,
    S_B_RDS,
    S_B_S,
    S_B_RDA,
    S_B_MUL,
    S_B_SUB,
    S_B_RDD,
    S_B_CHK,
    S_B_WAIT,
    S_SING,
    S_OUT,
    S_OUT_W
  } state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic [47:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (m >= 48'h0000_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(m[31:0]);
    end else begin
      if (m > 48'h0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(m[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = 33'(a) - 33'(b);
    if (d > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (d < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else r = d[31:0];
    return r;
  endfunction

  function automatic logic too_small(input logic signed [31:0] v, input logic [30:0] thr);
    logic [31:0] m;
    m = mag32(v);
    return (m == 32'd0) || (m < {1'b0, thr});
  endfunction

  function automatic logic [6:0] addr_of(input logic [2:0] r, input logic [3:0] c);
    return 7'(7'(r) * 7'(NumCol) + 7'(c));
  endfunction

endpackage
`default_nettype wire

@@ src/lss_div.sv @@
`default_nettype none
module lss_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [31:0]      q
);
  import lss_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_r;
  logic [47:0] dvd_r;
  logic [31:0] dvs_r;
  logic        neg_r;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r[31:0], dvd_r[47]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= {mag32(a), 16'd0};
      dvs_r <= mag32(b);
      neg_r <= a[31] ^ b[31];
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      dvd_r <= {dvd_r[46:0], fits};
    end
  end

  assign done = done_r;
  assign q    = sat_mag(dvd_r, neg_r);

endmodule
`default_nettype wire

@@ src/linear_system_solver_unit.sv @@
`default_nettype none
// channel | ports                                          | direction
// in      | in_valid in_stall in_row in_col in_value in_solve_req | load beat / solve start
// out     | out_valid out_stall out_sol_index out_sol_value out_status out_last | result beat
// cfg     | cfg_we cfg_index cfg_wdata                     | register write
// A solve copies the 72-word matrix into working memory, then runs on one read
// port and one write port of that memory: it reads each pivot candidate,
// updates each element, accumulates each back-substitution term and runs a
// serial divide per factor and per unknown. Each result beat is registered in
// S_OUT or S_SING and held in S_OUT_W until taken. Reset is synchronous;
// in_stall is high from the solve beat until the last result beat is taken.
module linear_system_solver_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_row,
  input  wire logic [3:0]         in_col,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_solve_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_sol_index,
  output logic signed [31:0]      out_sol_value,
  output logic                    out_status,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire lss_pkg::reg_idx_t  cfg_index,
  input  wire logic [30:0]        cfg_wdata
);
  import lss_pkg::*;

  logic signed [31:0] mat_mem [0:Depth-1];
  logic signed [31:0] work_mem [0:Depth-1];

  state_t st_r, st_nxt;
  logic [3:0]  size_r;
  logic [30:0] thr_r;
  logic [3:0]  n;
  logic [6:0]  cnt_r;
  logic [3:0]  i_r, k_r, j_r;
  logic [2:0]  perm_r [0:MaxSize-1];
  logic [31:0] best_r;
  logic signed [31:0] bestv_r;
  logic [2:0]  p_r;
  logic signed [31:0] piv_r, f_r, t_r, u_r, s_r;
  logic [63:0] prod_r;
  logic        neg_r;
  logic signed [31:0] x_r [0:MaxSize-1];
  logic signed [31:0] mat_rd_r, rd_r;
  logic [6:0]  rd_addr;
  logic        wr_en;
  logic [6:0]  wr_addr;
  logic signed [31:0] wr_data;
  logic        div_start, div_done;
  logic signed [31:0] div_a, div_b, div_q;
  logic        in_acc, out_acc;
  logic [3:0]  j_first, j_after;
  logic signed [31:0] prod_sat;

  assign n = (size_r == 4'd0) ? 4'd1 : (size_r > BCol) ? BCol : size_r;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT_W);

  assign j_first = (4'(i_r + 4'd1) < n) ? 4'(i_r + 4'd1) : BCol;
  assign j_after = (4'(j_r + 4'd1) < n) ? 4'(j_r + 4'd1) : BCol;
  assign prod_sat = sat_mag(prod_r[63:16], neg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 4'd8;
      thr_r  <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE: size_r <= cfg_wdata[3:0];
        REG_THR:  thr_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_col <= n)) begin
      mat_mem[addr_of(in_row, (in_col < n) ? in_col : BCol)] <= in_value;
    end
    if (cnt_r < 7'(Depth)) mat_rd_r <= mat_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en) work_mem[wr_addr] <= wr_data;
    rd_r <= work_mem[rd_addr];
  end

  lss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    div_start = 1'b0;
    div_a     = s_r;
    div_b     = rd_r;
    unique case (st_r)
      S_IDLE: if (in_acc && in_solve_req) st_nxt = S_COPY;
      S_COPY: begin
        wr_en   = (cnt_r != 7'd0);
        wr_addr = 7'(cnt_r - 7'd1);
        wr_data = mat_rd_r;
        if (cnt_r == 7'(Depth)) st_nxt = S_PIV_RD;
      end
      S_PIV_RD: begin
        rd_addr = addr_of(perm_r[k_r[2:0]], i_r);
        st_nxt  = S_PIV_CHK;
      end
      S_PIV_CHK: st_nxt = (4'(k_r + 4'd1) < n) ? S_PIV_RD : S_PIV_DEC;
      S_PIV_DEC: begin
        if (too_small(bestv_r, thr_r)) st_nxt = S_SING;
        else if (4'(i_r + 4'd1) < n) st_nxt = S_F_RD;
        else st_nxt = S_NEXT_I;
      end
      S_F_RD: begin
        rd_addr = addr_of(perm_r[k_r[2:0]], i_r);
        st_nxt  = S_F_DIV;
      end
      S_F_DIV: begin
        div_start = 1'b1;
        div_a     = rd_r;
        div_b     = piv_r;
        st_nxt    = S_F_WAIT;
      end
      S_F_WAIT: if (div_done) st_nxt = S_U_RDA;
      S_U_RDA: begin
        rd_addr = addr_of(perm_r[i_r[2:0]], j_r);
        st_nxt  = S_U_RDB;
      end
      S_U_RDB: begin
        rd_addr = addr_of(perm_r[k_r[2:0]], j_r);
        st_nxt  = S_U_MUL;
      end
      S_U_MUL: st_nxt = S_U_WR;
      S_U_WR: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(perm_r[k_r[2:0]], j_r);
        wr_data = qsub(u_r, prod_sat);
        if (j_r != BCol) st_nxt = S_U_RDA;
        else if (4'(k_r + 4'd1) < n) st_nxt = S_F_RD;
        else st_nxt = S_NEXT_I;
      end
      S_NEXT_I: st_nxt = (4'(i_r + 4'd1) < n) ? S_PIV_RD : S_B_RDS;
      S_B_RDS: begin
        rd_addr = addr_of(perm_r[i_r[2:0]], BCol);
        st_nxt  = S_B_S;
      end
      S_B_S: st_nxt = (4'(i_r + 4'd1) < n) ? S_B_RDA : S_B_RDD;
      S_B_RDA: begin
        rd_addr = addr_of(perm_r[i_r[2:0]], j_r);
        st_nxt  = S_B_MUL;
      end
      S_B_MUL: st_nxt = S_B_SUB;
      S_B_SUB: st_nxt = (4'(j_r + 4'd1) < n) ? S_B_RDA : S_B_RDD;
      S_B_RDD: begin
        rd_addr = addr_of(perm_r[i_r[2:0]], i_r);
        st_nxt  = S_B_CHK;
      end
      S_B_CHK: begin
        if (too_small(rd_r, thr_r)) st_nxt = S_SING;
        else begin
          div_start = 1'b1;
          st_nxt    = S_B_WAIT;
        end
      end
      S_B_WAIT: if (div_done) st_nxt = (i_r == 4'd0) ? S_OUT : S_B_RDS;
      S_SING: st_nxt = S_OUT_W;
      S_OUT: st_nxt = S_OUT_W;
      S_OUT_W: if (out_acc) st_nxt = out_last ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (st_r == S_COPY) cnt_r <= 7'(cnt_r + 7'd1);
    else cnt_r <= '0;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_COPY: begin
        for (int r = 0; r < MaxSize; r++) perm_r[r] <= 3'(r);
        i_r <= '0;
        k_r <= '0;
      end
      S_PIV_CHK: begin
        if ((k_r == i_r) || (mag32(rd_r) > best_r)) begin
          best_r  <= mag32(rd_r);
          bestv_r <= rd_r;
          p_r     <= k_r[2:0];
        end
        k_r <= 4'(k_r + 4'd1);
      end
      S_PIV_DEC: begin
        if (p_r != i_r[2:0]) begin
          perm_r[i_r[2:0]] <= perm_r[p_r];
          perm_r[p_r]      <= perm_r[i_r[2:0]];
        end
        piv_r            <= bestv_r;
        k_r              <= 4'(i_r + 4'd1);
      end
      S_F_WAIT: begin
        f_r <= div_q;
        j_r <= j_first;
      end
      S_U_RDB: t_r <= rd_r;
      S_U_MUL: begin
        u_r    <= rd_r;
        prod_r <= mag32(f_r) * mag32(t_r);
        neg_r  <= f_r[31] ^ t_r[31];
      end
      S_U_WR: begin
        if (j_r != BCol) j_r <= j_after;
        else begin
          k_r <= 4'(k_r + 4'd1);
        end
      end
      S_NEXT_I: begin
        if (4'(i_r + 4'd1) < n) begin
          i_r <= 4'(i_r + 4'd1);
          k_r <= 4'(i_r + 4'd1);
        end else begin
          i_r <= 4'(n - 4'd1);
        end
      end
      S_B_S: begin
        s_r <= rd_r;
        j_r <= 4'(i_r + 4'd1);
      end
      S_B_MUL: begin
        prod_r <= mag32(rd_r) * mag32(x_r[j_r[2:0]]);
        neg_r  <= rd_r[31] ^ x_r[j_r[2:0]][31];
      end
      S_B_SUB: begin
        s_r <= qsub(s_r, prod_sat);
        j_r <= 4'(j_r + 4'd1);
      end
      S_B_WAIT: begin
        if (div_done) begin
          x_r[i_r[2:0]] <= div_q;
          if (i_r == 4'd0) k_r <= '0;
          else i_r <= 4'(i_r - 4'd1);
        end
      end
      S_SING: begin
        out_sol_index <= '0;
        out_sol_value <= '0;
        out_status    <= 1'b1;
        out_last      <= 1'b1;
      end
      S_OUT: begin
        out_sol_index <= k_r[2:0];
        out_sol_value <= x_r[k_r[2:0]];
        out_status    <= 1'b0;
        out_last      <= (4'(k_r + 4'd1) == n);
        k_r           <= 4'(k_r + 4'd1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
